### sv/bdf_pkg.sv
// ----------------------------------------------------------------------------
// bdf_pkg: shared types and constants for the biquad filter
// Widths, register indexes, sequencer states and datapath control.
// ----------------------------------------------------------------------------
package bdf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 24;
	localparam int COEF_FRAC  = 20;
	localparam int STATE_W    = 32;
	localparam int STATE_FRAC = 8;
	localparam int PROD_W     = COEF_W + STATE_W;
	localparam int RPROD_W    = PROD_W + 1 - COEF_FRAC;
	localparam int ACC_W      = STATE_W + 8;
	localparam int IDX_W      = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_A1 = 3'd0,
		REG_A2 = 3'd1,
		REG_B0 = 3'd2,
		REG_B1 = 3'd3,
		REG_B2 = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_A2,
		ST_W0,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OPND_A1W1,
		OPND_A2W2,
		OPND_B0W0,
		OPND_B1W1,
		OPND_B2W2
	} opnd_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB,
		ACC_CLEAR
	} acc_op_t;

	typedef struct packed {
		opnd_t   opnd;
		acc_op_t acc_op;
		logic    load_w0;
		logic    load_out;
	} ctrl_t;

endpackage

### sv/biquad_df2_filter.sv
// ----------------------------------------------------------------------------
// biquad_df2_filter: direct-form II second-order IIR section
// Coefficient registers, delay words, operand select and result register.
// ----------------------------------------------------------------------------
// The accepting cycle loads the scaled sample and starts the a1 product.
// The single shared 24x32 multiplier, registered once, then serves a2,
// b0, b1 and b2 in turn. State W0 subtracts the last feedback term and
// saturates the new delay word, and state ACC adds the last feedforward
// term. State OUT rounds and saturates the output into the result register.
// in_ready is high only while the sequencer is idle, so the next sample
// enters on the cycle after the result loads. The result register lets the
// next sample enter while the previous result still waits downstream. A
// sample that catches up with an untaken result holds in the last step
// until that result is taken. Coefficients are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no sample is
// in flight, as the block itself does not enforce it.
module biquad_df2_filter
	import bdf_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [COEF_W-1:0]          cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       clipped
);

	localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) <<< (STATE_FRAC - 1);

	logic signed [COEF_W-1:0]   coef_a1_q, coef_a2_q, coef_b0_q, coef_b1_q, coef_b2_q;
	logic signed [STATE_W-1:0]  delay_one_q, delay_two_q, w0_q;
	logic signed [COEF_W-1:0]   mul_coef;
	logic signed [STATE_W-1:0]  mul_w;
	logic signed [ACC_W-1:0]    load_val, acc_nxt, acc_q, y_rnd;
	logic signed [STATE_W-1:0]  y_full;
	logic signed [STATE_W-1:0]  w0_sat;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic                       w0_hit, y_hit, clip_q, out_free;
	ctrl_t                      ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a1_q <= '0;
			coef_a2_q <= '0;
			coef_b0_q <= COEF_W'(1) <<< COEF_FRAC;
			coef_b1_q <= '0;
			coef_b2_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_A1:  coef_a1_q <= cfg_data;
				REG_A2:  coef_a2_q <= cfg_data;
				REG_B0:  coef_b0_q <= cfg_data;
				REG_B1:  coef_b1_q <= cfg_data;
				REG_B2:  coef_b2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid || out_ready;

	bdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	always_comb begin
		unique case (ctrl.opnd)
			OPND_A1W1: begin mul_coef = coef_a1_q; mul_w = delay_one_q; end
			OPND_A2W2: begin mul_coef = coef_a2_q; mul_w = delay_two_q; end
			OPND_B0W0: begin mul_coef = coef_b0_q; mul_w = w0_q;        end
			OPND_B1W1: begin mul_coef = coef_b1_q; mul_w = delay_one_q; end
			OPND_B2W2: begin mul_coef = coef_b2_q; mul_w = delay_two_q; end
			default:   begin mul_coef = coef_a1_q; mul_w = delay_one_q; end
		endcase
	end

	assign load_val = ACC_W'(sample_in) <<< STATE_FRAC;

	bdf_mac u_mac (
		.clk      (clk),
		.coef     (mul_coef),
		.opnd_w   (mul_w),
		.acc_op   (ctrl.acc_op),
		.load_val (load_val),
		.acc_nxt  (acc_nxt),
		.acc_q    (acc_q)
	);

	// saturate new delay word
	assign w0_hit = !((&acc_nxt[ACC_W-1:STATE_W-1]) || !(|acc_nxt[ACC_W-1:STATE_W-1]));
	always_comb begin
		if (!w0_hit) begin
			w0_sat = acc_nxt[STATE_W-1:0];
		end else if (acc_nxt[ACC_W-1]) begin
			w0_sat = {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			w0_sat = {1'b0, {(STATE_W-1){1'b1}}};
		end
	end

	// round and saturate output
	assign y_rnd  = acc_q + Y_HALF;
	assign y_full = y_rnd[STATE_W+STATE_FRAC-1:STATE_FRAC];
	assign y_hit  = !((&y_rnd[ACC_W-1:SAMPLE_W+STATE_FRAC-1])
		|| !(|y_rnd[ACC_W-1:SAMPLE_W+STATE_FRAC-1]));
	always_comb begin
		if (!y_hit) begin
			y_sat = y_full[SAMPLE_W-1:0];
		end else if (y_rnd[ACC_W-1]) begin
			y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_w0) begin
			w0_q   <= w0_sat;
			clip_q <= w0_hit;
		end
		if (ctrl.load_out) begin
			sample_out <= y_sat;
			clipped    <= clip_q || y_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_one_q <= '0;
			delay_two_q <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (ctrl.load_out) begin
				delay_two_q <= delay_one_q;
				delay_one_q <= w0_q;
			end
			if (ctrl.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after an accepted item");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> (!out_valid || out_ready))
		else $error("result register overwritten while occupied");

	a_w0_on_subtract: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_w0 |-> (ctrl.acc_op == ACC_SUB))
		else $error("delay word captured outside the feedback subtract");

	a_delay_shift: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |=> (delay_two_q == $past(delay_one_q)))
		else $error("delay line did not advance");

	a_ready_excludes_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!ctrl.load_out && !ctrl.load_w0))
		else $error("idle sequencer driving datapath loads");
`endif

endmodule

### sv/bdf_mac.sv
// ----------------------------------------------------------------------------
// bdf_mac: shared multiply, round and accumulate unit
// One registered 24x32 product per cycle, rounded to the delay-word grid
// and added into or subtracted from a wide accumulator.
// ----------------------------------------------------------------------------
module bdf_mac
	import bdf_pkg::*;
(
	input  logic                     clk,
	input  logic signed [COEF_W-1:0] coef,
	input  logic signed [STATE_W-1:0] opnd_w,
	input  acc_op_t                  acc_op,
	input  logic signed [ACC_W-1:0]  load_val,
	output logic signed [ACC_W-1:0]  acc_nxt,
	output logic signed [ACC_W-1:0]  acc_q
);

	localparam logic signed [PROD_W:0] RND_HALF = (PROD_W+1)'(1) <<< (COEF_FRAC - 1);

	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [PROD_W:0]    rsum;
	logic signed [RPROD_W-1:0] rprod;
	logic signed [ACC_W-1:0]   rprod_x;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(coef) * PROD_W'(opnd_w);
	end

	assign rsum    = (PROD_W+1)'(prod_s1) + RND_HALF;
	assign rprod   = rsum[PROD_W:COEF_FRAC];
	assign rprod_x = ACC_W'(rprod);

	always_comb begin
		unique case (acc_op)
			ACC_HOLD:  acc_nxt = acc_q;
			ACC_LOAD:  acc_nxt = load_val;
			ACC_ADD:   acc_nxt = acc_q + rprod_x;
			ACC_SUB:   acc_nxt = acc_q - rprod_x;
			ACC_CLEAR: acc_nxt = '0;
			default:   acc_nxt = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_nxt;
	end

endmodule

### sv/bdf_ctrl.sv
// ----------------------------------------------------------------------------
// bdf_ctrl: sample sequencer
// Steps the shared multiplier through the feedback and feedforward terms.
// ----------------------------------------------------------------------------
module bdf_ctrl
	import bdf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_free,
	output logic  in_ready,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_A2;
			ST_A2:   state_nxt = ST_W0;
			ST_W0:   state_nxt = ST_B0;
			ST_B0:   state_nxt = ST_B1;
			ST_B1:   state_nxt = ST_B2;
			ST_B2:   state_nxt = ST_ACC;
			ST_ACC:  state_nxt = ST_OUT;
			ST_OUT:  if (out_free) state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		ctrl.opnd     = OPND_A1W1;
		ctrl.acc_op   = ACC_HOLD;
		ctrl.load_w0  = 1'b0;
		ctrl.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) ctrl.acc_op = ACC_LOAD;
			end
			ST_A2: begin
				ctrl.opnd   = OPND_A2W2;
				ctrl.acc_op = ACC_SUB;
			end
			ST_W0: begin
				ctrl.acc_op  = ACC_SUB;
				ctrl.load_w0 = 1'b1;
			end
			ST_B0: begin
				ctrl.opnd   = OPND_B0W0;
				ctrl.acc_op = ACC_CLEAR;
			end
			ST_B1: begin
				ctrl.opnd   = OPND_B1W1;
				ctrl.acc_op = ACC_ADD;
			end
			ST_B2: begin
				ctrl.opnd   = OPND_B2W2;
				ctrl.acc_op = ACC_ADD;
			end
			ST_ACC: begin
				ctrl.acc_op = ACC_ADD;
			end
			ST_OUT: begin
				ctrl.load_out = out_free;
			end
		endcase
	end

endmodule

### verif/biquad_df2_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_df2_filter_tb: self-checking testbench for the biquad filter
// Writes coefficient sets between runs of samples, predicts each filtered
// sample and clip flag with a bit-exact fixed-point model, and checks every
// output item in order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module biquad_df2_filter_tb;
	import bdf_pkg::*;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clip;
	} filtered_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       cfg_we     = 1'b0;
	logic [IDX_W-1:0]           cfg_index  = '0;
	logic [COEF_W-1:0]          cfg_data   = '0;
	logic                       in_valid   = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_in  = '0;
	logic                       out_valid;
	logic                       out_ready  = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       clipped;

	logic signed [COEF_W-1:0]  m_a1, m_a2, m_b0, m_b1, m_b2;
	logic signed [STATE_W-1:0] m_w1, m_w2;
	filtered_t                 filtered_q[$];
	int                        send_idle_pct  = 0;
	int                        recv_stall_pct = 0;
	int                        mismatch_count = 0;

	biquad_df2_filter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint round_mul(longint c, longint w);
		longint p;
		p = c * w + (longint'(1) << (COEF_FRAC - 1));
		return p >>> COEF_FRAC;
	endfunction

	function automatic longint saturate(longint v, int width, inout bit hit);
		longint hi;
		longint lo;
		hi = (longint'(1) << (width - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic filtered_t filter_sample(logic signed [SAMPLE_W-1:0] x);
		filtered_t r;
		longint    w0;
		longint    acc;
		longint    y;
		bit        hit;
		hit = 1'b0;
		w0  = (longint'(x) <<< STATE_FRAC) - round_mul(m_a1, m_w1) - round_mul(m_a2, m_w2);
		w0  = saturate(w0, STATE_W, hit);
		acc = round_mul(m_b0, w0) + round_mul(m_b1, m_w1) + round_mul(m_b2, m_w2);
		y   = (acc + (longint'(1) << (STATE_FRAC - 1))) >>> STATE_FRAC;
		y   = saturate(y, SAMPLE_W, hit);
		m_w2 = m_w1;
		m_w1 = w0[STATE_W-1:0];
		r.sample = y[SAMPLE_W-1:0];
		r.clip   = hit;
		return r;
	endfunction

	always @(posedge clk) begin
		filtered_t exp_item;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (filtered_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected item sample_out %0d clipped %0b",
						$time, sample_out, clipped);
				end else begin
					exp_item = filtered_q.pop_front();
					if (sample_out !== exp_item.sample) begin
						mismatch_count++;
						$display("%0t: sample_out expected %0d actual %0d",
							$time, exp_item.sample, sample_out);
					end
					if (clipped !== exp_item.clip) begin
						mismatch_count++;
						$display("%0t: clipped expected %0b actual %0b",
							$time, exp_item.clip, clipped);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (reg_idx_t'(idx))
			REG_A1: m_a1 = data;
			REG_A2: m_a2 = data;
			REG_B0: m_b0 = data;
			REG_B1: m_b1 = data;
			REG_B2: m_b2 = data;
			default: ;
		endcase
	endtask

	task automatic load_coefs(input int a1, input int a2, input int b0, input int b1,
		input int b2);
		write_reg(REG_A1, a1[COEF_W-1:0]);
		write_reg(REG_A2, a2[COEF_W-1:0]);
		write_reg(REG_B0, b0[COEF_W-1:0]);
		write_reg(REG_B1, b1[COEF_W-1:0]);
		write_reg(REG_B2, b2[COEF_W-1:0]);
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= x;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		filtered_q.push_back(filter_sample(x));
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (filtered_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic test_passthrough();
		set_idling(12, 12);
		send_sample(16'sd0);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		pause_until_drained();
	endtask

	task automatic test_ignored_index();
		for (int k = int'(REG_B2) + 1; k < 2 ** IDX_W; k++)
			write_reg(k[IDX_W-1:0], COEF_W'($urandom()));
		cfg_we <= 1'b0;
		set_idling(0, 0);
		send_sample(16'sd1234);
		send_sample(-16'sd20000);
		send_sample(16'sd7);
		pause_until_drained();
	endtask

	task automatic test_output_clip();
		load_coefs(0, 0, 8388607, -8388608, 8388607);
		set_idling(0, 55);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd4096);
		send_sample(16'sd0);
		pause_until_drained();
	endtask

	task automatic test_delay_clip();
		load_coefs(-8388608, -8388608, 1, 0, 0);
		set_idling(55, 0);
		send_sample(16'sd32767);
		send_sample(16'sd32767);
		send_sample(16'sd32767);
		send_sample(16'sd32767);
		pause_until_drained();
		load_coefs(8388607, 8388607, 65536, -1, 1);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		pause_until_drained();
	endtask

	task automatic test_random_filters();
		int lim;
		int a2;
		int amp;
		int pick;
		logic signed [SAMPLE_W-1:0] x;
		for (int phase = 0; phase < 8; phase++) begin
			if (phase % 3 == 2) begin
				load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
			end else begin
				a2  = int'($urandom_range(1400000)) - 500000;
				lim = 1048576 + a2 - 60000;
				load_coefs(int'($urandom_range(2 * lim)) - lim, a2,
					int'($urandom_range(2097152)) - 1048576,
					int'($urandom_range(2097152)) - 1048576,
					int'($urandom_range(2097152)) - 1048576);
			end
			case (phase % 4)
				0: set_idling(0, 0);
				1: set_idling(55, 0);
				2: set_idling(0, 55);
				default: set_idling(12, 12);
			endcase
			amp = 1 << $urandom_range(15, 4);
			for (int n = 0; n < 215; n++) begin
				pick = $urandom_range(9);
				if (pick < 5)
					x = SAMPLE_W'($urandom());
				else if (pick < 9)
					x = SAMPLE_W'(int'($urandom_range(2 * amp - 1)) - amp);
				else
					x = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
				send_sample(x);
				if (n == 107)
					pause_until_drained();
			end
			pause_until_drained();
		end
	endtask

	initial begin
		m_a1 = '0;
		m_a2 = '0;
		m_b0 = COEF_W'(1 << COEF_FRAC);
		m_b1 = '0;
		m_b2 = '0;
		m_w1 = '0;
		m_w2 = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_ignored_index();
		test_output_clip();
		test_delay_clip();
		test_random_filters();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && filtered_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
